### hdl/elgamal_modexp_crypt_top_defines.svh
// Assertion macros for the modular exponentiation block.
`ifndef ELGAMAL_MODEXP_CRYPT_TOP_DEFINES_SVH
`define ELGAMAL_MODEXP_CRYPT_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define EMC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define EMC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define EMC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define EMC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/emc_pkg.sv
// Shared constants and types for the modular exponentiation block.
package emc_pkg;
   localparam int ModBitsDefault = 32;
   localparam int FieldBits = 32;
   localparam int ModulusReset = 379;
   localparam int GeneratorReset = 360;
   localparam int PublicReset = 1;
   localparam int PrivateReset = 67;

   typedef enum logic [1:0] {
      CSR_MODULUS = 2'd0,
      CSR_GENERATOR = 2'd1,
      CSR_PUBLIC = 2'd2,
      CSR_PRIVATE = 2'd3
   } csr_index_type;
endpackage

### hdl/emc_mulmod.sv
// Bit-serial modular multiplier: one add-and-double step per cycle.
module emc_mulmod #(
   parameter int MOD_BITS = emc_pkg::ModBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [MOD_BITS-1:0] op_x,
   input  logic [MOD_BITS-1:0] op_y,
   input  logic [MOD_BITS-1:0] modulus,
   output logic                done,
   output logic [MOD_BITS-1:0] product
);
   import emc_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [MOD_BITS-1:0] x_ff, x_in;
   logic [MOD_BITS-1:0] y_ff, y_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS:0]   acc_sum;
   logic [MOD_BITS:0]   dbl_sum;

   always_comb begin
      acc_sum = {1'b0, acc_ff} + {1'b0, x_ff};
      dbl_sum = {1'b0, x_ff} + {1'b0, x_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      x_in = x_ff;
      y_in = y_ff;
      acc_in = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in = op_x;
         y_in = op_y;
         acc_in = '0;
      end else if (busy_ff) begin
         if (y_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            if (y_ff[0]) begin
               acc_in = (acc_sum >= {1'b0, modulus}) ?
                  MOD_BITS'(acc_sum - {1'b0, modulus}) : acc_sum[MOD_BITS-1:0];
            end
            x_in = (dbl_sum >= {1'b0, modulus}) ?
               MOD_BITS'(dbl_sum - {1'b0, modulus}) : dbl_sum[MOD_BITS-1:0];
            y_in = y_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

### hdl/elgamal_modexp_crypt_top.sv
// ElGamal encrypt and decrypt block built on a shared bit-serial modular multiplier.
// Steps: the message and then the base are reduced; then, per exponent bit, a set bit
// multiplies the base into the accumulator and the base is squared, and the message is
// multiplied in last. A key fault answers in the cycle after accept. Throughput is one
// word at a time; the next word is accepted the cycle after the result is taken. Reset
// is synchronous and restores the default registers.
`include "elgamal_modexp_crypt_top_defines.svh"
module elgamal_modexp_crypt_top #(
   parameter int MOD_BITS = emc_pkg::ModBitsDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  emc_pkg::csr_index_type csr_index,
   input  logic [MOD_BITS-1:0] csr_data,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [31:0]         req_message,
   input  logic [31:0]         req_cipher_first,
   input  logic [31:0]         req_ephemeral,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [31:0]         rsp_value_a,
   output logic [31:0]         rsp_value_b,
   output logic                rsp_fault
);
   import emc_pkg::*;

   localparam int CntBits = $clog2(MOD_BITS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RED_MSG, S_RED_BASE, S_EXP_BIT, S_MUL_ACC, S_WAIT_ACC,
      S_MUL_SQ, S_WAIT_SQ, S_NEXT, S_FINAL, S_WAIT_FIN, S_OUT
   } state_type;

   logic [MOD_BITS-1:0] mod_ff, gen_ff, pub_ff, priv_ff;
   state_type           state_ff;
   logic                kind_ff, pass_ff, fault_ff, rsp_valid_ff;
   logic [MOD_BITS-1:0] msg_ff, c1_ff, r_ff, d_exp_ff;
   logic [MOD_BITS-1:0] base_ff, exp_ff, acc_ff, acc2_ff, res_a_ff, res_b_ff;
   logic [MOD_BITS-1:0] rem_ff, sub_ff;
   logic [CntBits-1:0]  cnt_ff;
   logic [MOD_BITS:0]   rem_sh;
   logic                mul_start_ff;
   logic [MOD_BITS-1:0] mul_x_ff, mul_y_ff;
   logic                mul_done;
   logic [MOD_BITS-1:0] mul_p;
   logic                key_bad;
   logic [MOD_BITS-1:0] src_ext;

   emc_mulmod #(.MOD_BITS(MOD_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start_ff), .op_x(mul_x_ff),
      .op_y(mul_y_ff), .modulus(mod_ff), .done(mul_done), .product(mul_p)
   );

   assign key_bad = (mod_ff < MOD_BITS'(3)) || (priv_ff > mod_ff - MOD_BITS'(2));
   assign rem_sh = {rem_ff, sub_ff[MOD_BITS-1]};
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value_a = 32'(res_a_ff);
   assign rsp_value_b = 32'(res_b_ff);
   assign rsp_fault = fault_ff;

   always_comb begin
      src_ext = '0;
      src_ext[MOD_BITS-1:0] = MOD_BITS'(req_message);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_BITS'(ModulusReset);
         gen_ff <= MOD_BITS'(GeneratorReset);
         pub_ff <= MOD_BITS'(PublicReset);
         priv_ff <= MOD_BITS'(PrivateReset);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MODULUS: mod_ff <= csr_data;
            CSR_GENERATOR: gen_ff <= csr_data;
            CSR_PUBLIC: pub_ff <= csr_data;
            CSR_PRIVATE: priv_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_start_ff <= 1'b0;
         fault_ff <= 1'b0;
      end else begin
         mul_start_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff <= req_kind;
                  msg_ff <= src_ext;
                  c1_ff <= MOD_BITS'(req_cipher_first);
                  r_ff <= MOD_BITS'(req_ephemeral);
                  d_exp_ff <= mod_ff - MOD_BITS'(1) - priv_ff;
                  pass_ff <= 1'b0;
                  res_b_ff <= '0;
                  if (key_bad) begin
                     res_a_ff <= '0;
                     fault_ff <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     fault_ff <= 1'b0;
                     sub_ff <= src_ext;
                     rem_ff <= '0;
                     cnt_ff <= CntBits'(MOD_BITS);
                     state_ff <= S_RED_MSG;
                  end
               end
            end
            S_RED_MSG, S_RED_BASE: begin
               // Restoring reduction, one dividend bit per cycle.
               sub_ff <= sub_ff << 1;
               rem_ff <= (rem_sh >= {1'b0, mod_ff}) ?
                  MOD_BITS'(rem_sh - {1'b0, mod_ff}) : rem_sh[MOD_BITS-1:0];
               cnt_ff <= cnt_ff - CntBits'(1);
               if (cnt_ff == CntBits'(1)) begin
                  cnt_ff <= CntBits'(MOD_BITS);
                  if (state_ff == S_RED_MSG) begin
                     msg_ff <= (rem_sh >= {1'b0, mod_ff}) ?
                        MOD_BITS'(rem_sh - {1'b0, mod_ff}) : rem_sh[MOD_BITS-1:0];
                     rem_ff <= '0;
                     sub_ff <= kind_ff ? c1_ff : (pass_ff ? pub_ff : gen_ff);
                     exp_ff <= kind_ff ? d_exp_ff : r_ff;
                     state_ff <= S_RED_BASE;
                  end else begin
                     base_ff <= (rem_sh >= {1'b0, mod_ff}) ?
                        MOD_BITS'(rem_sh - {1'b0, mod_ff}) : rem_sh[MOD_BITS-1:0];
                     acc_ff <= MOD_BITS'(1);
                     state_ff <= S_EXP_BIT;
                  end
               end
            end
            S_EXP_BIT: begin
               if (exp_ff == '0) begin
                  state_ff <= S_FINAL;
               end else if (exp_ff[0]) begin
                  mul_x_ff <= acc_ff;
                  mul_y_ff <= base_ff;
                  mul_start_ff <= 1'b1;
                  state_ff <= S_WAIT_ACC;
               end else begin
                  state_ff <= S_MUL_SQ;
               end
            end
            S_WAIT_ACC: begin
               if (mul_done) begin
                  acc_ff <= mul_p;
                  state_ff <= S_MUL_SQ;
               end
            end
            S_MUL_SQ: begin
               mul_x_ff <= base_ff;
               mul_y_ff <= base_ff;
               mul_start_ff <= 1'b1;
               state_ff <= S_WAIT_SQ;
            end
            S_WAIT_SQ: begin
               if (mul_done) begin
                  base_ff <= mul_p;
                  exp_ff <= exp_ff >> 1;
                  state_ff <= S_EXP_BIT;
               end
            end
            S_FINAL: begin
               if (!kind_ff && !pass_ff) begin
                  acc2_ff <= acc_ff;
                  pass_ff <= 1'b1;
                  rem_ff <= '0;
                  sub_ff <= pub_ff;
                  exp_ff <= r_ff;
                  cnt_ff <= CntBits'(MOD_BITS);
                  state_ff <= S_RED_BASE;
               end else begin
                  mul_x_ff <= msg_ff;
                  mul_y_ff <= acc_ff;
                  mul_start_ff <= 1'b1;
                  state_ff <= S_WAIT_FIN;
               end
            end
            S_WAIT_FIN: begin
               if (mul_done) begin
                  if (kind_ff) begin
                     res_a_ff <= mul_p;
                     res_b_ff <= '0;
                  end else begin
                     res_a_ff <= acc2_ff;
                     res_b_ff <= mul_p;
                  end
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `EMC_ASSERT_IMPL(a_out_valid, clock, reset, rsp_valid, state_ff == S_OUT)
   `EMC_ASSERT_IMPL(a_fault_zero, clock, reset, rsp_valid && rsp_fault, rsp_value_a == 32'd0)
   `EMC_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule
